// ===== sv/imufp_pkg.sv =====
// ----------------------------------------------------------------------------
// imufp_pkg
// Shared types and constants for the IMU frame parser.
// ----------------------------------------------------------------------------
package imufp_pkg;

    localparam logic [7:0] HDR1      = 8'hA7;
    localparam logic [7:0] HDR2      = 8'h7A;
    localparam logic [7:0] TYPE_BASE = 8'h70;
    localparam logic [7:0] TYPE_LAST = 8'h75;

    localparam int PAYLOAD_DEPTH = 6;
    localparam int TDATA_W       = 96;
    localparam int TUSER_W       = 3;

    localparam logic [2:0] KIND_MAG  = 3'd3;
    localparam logic [2:0] KIND_TEMP = 3'd4;
    localparam logic [2:0] KIND_ALT  = 3'd5;

    localparam logic [2:0] NEED_SHORT = 3'd4;
    localparam logic [2:0] NEED_LONG  = 3'd6;

    // 52429 / 2^19 gives exact division by ten for magnitudes up to 43689
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [2:0]                          kind;
        logic [PAYLOAD_DEPTH-1:0][7:0]       bytes;
    } frame_t;

endpackage

// ===== sv/imufp_parser.sv =====
// ----------------------------------------------------------------------------
// imufp_parser
// Byte-wise header hunt and frame assembly; holds one completed frame.
// ----------------------------------------------------------------------------
module imufp_parser
    import imufp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // rx_byte[7:0]
    output logic       frame_valid,
    output frame_t     frame,
    input  logic       frame_take
);

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_TYPE,
        PH_LEN,
        PH_CHK,
        PH_PAYLOAD
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [2:0]                   kind_reg, kind_next;
    logic [2:0]                   idx_reg, idx_next;
    logic [PAYLOAD_DEPTH-1:0][7:0] payload_reg, payload_next;
    logic                         frame_valid_reg, frame_valid_next;
    frame_t                       frame_reg, frame_next;

    logic       accept;
    logic [2:0] need;
    logic [2:0] widx;
    logic [2:0] cnt;

    assign s_tready    = !frame_valid_reg || frame_take;
    assign accept      = s_tvalid && s_tready;
    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

    assign need = (kind_reg == KIND_ALT) ? NEED_SHORT : NEED_LONG;
    assign widx = (idx_reg >= need) ? 3'd0 : idx_reg;
    assign cnt  = widx + 3'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        payload_next     = payload_reg;
        frame_valid_next = frame_valid_reg && !frame_take;
        frame_next       = frame_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT1:
                begin
                    if (s_tdata == HDR1)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    phase_next = (s_tdata == HDR2) ? PH_TYPE : PH_HUNT1;
                end
                PH_TYPE:
                begin
                    if (s_tdata >= TYPE_BASE && s_tdata <= TYPE_LAST)
                    begin
                        kind_next  = 3'(s_tdata - TYPE_BASE);
                        idx_next   = 3'd0;
                        phase_next = PH_LEN;
                    end
                    else
                        phase_next = PH_HUNT1;
                end
                PH_LEN:
                begin
                    phase_next = PH_CHK;
                end
                PH_CHK:
                begin
                    phase_next = PH_PAYLOAD;
                    idx_next   = 3'd0;
                end
                PH_PAYLOAD:
                begin
                    payload_next[widx] = s_tdata;
                    if (cnt == need)
                    begin
                        frame_next.kind  = kind_reg;
                        frame_next.bytes = payload_next;
                        frame_valid_next = 1'b1;
                        phase_next       = PH_HUNT1;
                        idx_next         = 3'd0;
                    end
                    else
                        idx_next = cnt;
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT1;
            kind_reg        <= 3'd0;
            idx_reg         <= 3'd0;
            payload_reg     <= '0;
            frame_valid_reg <= 1'b0;
            frame_reg       <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            kind_reg        <= kind_next;
            idx_reg         <= idx_next;
            payload_reg     <= payload_next;
            frame_valid_reg <= frame_valid_next;
            frame_reg       <= frame_next;
        end
    end

endmodule

// ===== sv/imufp_result.sv =====
// ----------------------------------------------------------------------------
// imufp_result
// Unpacks a completed frame into result fields and holds the output item.
// ----------------------------------------------------------------------------
module imufp_result
    import imufp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    input  frame_t             frame,
    output logic               frame_take,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // axis_x, axis_y, axis_z, temperature, long_value, pad
    output logic [TUSER_W-1:0] m_tuser   // frame_kind
);

    logic               out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0] data_reg, data_next;
    logic [TUSER_W-1:0] user_reg, user_next;

    logic [15:0] w0, w1, w2;
    logic        neg;
    logic [15:0] mag;
    logic [31:0] prod;
    logic [12:0] quo;
    logic [15:0] ax, ay, az;
    logic [12:0] tmp;
    logic [31:0] lv;

    assign frame_take = frame_valid && (!out_valid_reg || m_tready);

    assign w0 = {frame.bytes[1], frame.bytes[0]};
    assign w1 = {frame.bytes[3], frame.bytes[2]};
    assign w2 = {frame.bytes[5], frame.bytes[4]};

    // signed word / 10, truncated toward zero
    assign neg  = w0[15];
    assign mag  = neg ? 16'(-w0) : w0;
    assign prod = mag * RECIP_TEN;
    assign quo  = prod[RECIP_SHIFT +: 13];

    always_comb
    begin
        ax  = 16'd0;
        ay  = 16'd0;
        az  = 16'd0;
        tmp = 13'd0;
        lv  = 32'd0;
        if (frame.kind <= KIND_MAG)
        begin
            ax = w0;
            ay = w1;
            az = w2;
        end
        else if (frame.kind == KIND_TEMP)
        begin
            tmp = neg ? 13'(-quo) : quo;
            lv  = {w2, w1};
        end
        else if (frame.kind == KIND_ALT)
            lv = {w1, w0};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        data_next      = data_reg;
        user_next      = user_reg;
        if (frame_take)
        begin
            out_valid_next = 1'b1;
            data_next      = {3'd0, lv, tmp, az, ay, ax};
            user_next      = frame.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

// ===== sv/imu_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// imu_frame_parser_unit
// Parses IMU frames from a stream of received serial bytes.
// ----------------------------------------------------------------------------
// Slave stream: one received byte per item on s_tdata[7:0].
// Master stream: one item per complete frame; frame kind on m_tuser,
// axis words, temperature and long value packed in m_tdata.
// Throughput: one byte per cycle while s_tready is high, set by the parser state register which
// handles each byte in the cycle it is accepted.
// Flow: the last payload byte of a frame is registered into the frame register
// on acceptance and then moves into the output register, which drives m_tvalid,
// once that register is empty or being drained.
// Each stage holds one item; a stalled receiver fills the output register
// and then the frame register, after which s_tready drops until the
// frame register drains. Bytes are not dropped under backpressure.
// Reset clears the parser to the header hunt and empties both stages;
// the output data register is not cleared.
// ----------------------------------------------------------------------------
module imu_frame_parser_unit
    import imufp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // rx_byte[7:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // axis_x, axis_y, axis_z, temperature, long_value, pad
    output logic [TUSER_W-1:0] m_tuser    // frame_kind
);

    logic   frame_valid;
    frame_t frame;
    logic   frame_take;

    imufp_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_take  (frame_take)
    );

    imufp_result u_result
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_take  (frame_take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= KIND_ALT))
        else $error("output kind out of range");

    a_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser > KIND_MAG) |-> (m_tdata[47:0] == 48'd0))
        else $error("axis words set on a non-axis frame");

    a_axis_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser <= KIND_MAG) |-> (m_tdata[95:48] == 48'd0))
        else $error("temperature or long value set on an axis frame");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (frame_valid && m_tvalid && !m_tready))
        else $error("input stalled with room in the pipeline");

    a_take_moves: assert property (@(posedge clk) disable iff (!rst_n)
        frame_take |=> m_tvalid)
        else $error("taken frame did not reach the output");

endmodule
